// ===== hdl/i2crm_pkg.sv =====
// Shared types, codes and constants for the I2C register master.
package i2crm_pkg;

  localparam int COUNT_BITS_DEFAULT = 8;
  localparam int APB_ADDR_W         = 3;
  localparam int APB_DATA_W         = 32;

  localparam logic [15:0] PHASE_TICKS_RESET    = 16'd4;
  localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd100;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic REG_PHASE_TICKS    = 1'b0;
  localparam logic REG_ACK_POLL_LIMIT = 1'b1;

  typedef enum logic [20:0] {
    PH_IDLE      = 21'h000001,
    PH_ST_SDA_HI = 21'h000002,
    PH_ST_SCL_HI = 21'h000004,
    PH_ST_SDA_LO = 21'h000008,
    PH_ST_SCL_LO = 21'h000010,
    PH_TX_SETUP  = 21'h000020,
    PH_TX_HIGH   = 21'h000040,
    PH_TX_TAIL   = 21'h000080,
    PH_ACK_REL   = 21'h000100,
    PH_ACK_SCLH  = 21'h000200,
    PH_ACK_POLL  = 21'h000400,
    PH_ACK_SCLL  = 21'h000800,
    PH_RX_REL    = 21'h001000,
    PH_RX_HIGH   = 21'h002000,
    PH_RX_LOW    = 21'h004000,
    PH_MACK_SDA  = 21'h008000,
    PH_MACK_SCLH = 21'h010000,
    PH_MACK_SCLL = 21'h020000,
    PH_SP_SDA_LO = 21'h040000,
    PH_SP_SCL_HI = 21'h080000,
    PH_SP_SDA_HI = 21'h100000
  } phase_t;

  typedef enum logic [3:0] {
    ST_ADDRW = 4'b0001,
    ST_REG   = 4'b0010,
    ST_DATA  = 4'b0100,
    ST_ADDRR = 4'b1000
  } stage_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] dev_addr;
    logic [7:0] target_reg;
    logic [7:0] byte_count;
    logic [7:0] wr_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic       byte_taken;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       done_res;
    logic       nack_error;
  } result_t;

endpackage

// ===== hdl/i2c_register_master.sv =====
// I2C register master: tick-driven bus sequencer with APB configuration.
//
// Each accepted item is one timing tick of the bus sequencer. One tick is
// accepted per cycle while the output register is empty or freed; the
// whole sequencer update for a tick is a single pass of next-state logic
// between the state registers and the output register, which captures
// the result on acceptance. While a result waits for result_ready, a new
// tick is still taken if the output register is freed in the same cycle.
// Register phase_ticks (address 0) sets how many ticks each SCL/SDA step
// lasts, ack_poll_limit (address 4) how many high polls of SDA are tolerated
// before a missing acknowledge ends the transfer with stop and nack_error.
module i2c_register_master #(
  parameter int COUNT_BITS = i2crm_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  i2crm_pkg::item_t                  item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output i2crm_pkg::result_t                result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2crm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [i2crm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [i2crm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import i2crm_pkg::*;

  logic [15:0]           phase_ticks;
  logic [7:0]            ack_poll_limit;

  phase_t                phase, phase_next;
  stage_t                stage, stage_next;
  logic [15:0]           tick_count, tick_count_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [COUNT_BITS-1:0] bytes_left, bytes_left_next;
  logic [7:0]            poll_count, poll_count_next;
  logic [6:0]            device_latch, device_latch_next;
  logic [7:0]            register_latch, register_latch_next;
  logic                  read_mode, read_mode_next;
  logic                  scl_level, scl_level_next;
  logic                  sda_level, sda_level_next;
  logic                  err_flag, err_flag_next;

  result_t               result_next;
  logic                  advance;
  logic                  cfg_write;

  logic                  go;
  phase_t                go_phase;
  logic                  taken;
  logic                  rd_ok;
  logic                  done;
  logic                  nack;
  logic [COUNT_BITS+7:0] count_ext;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign item_ready = !result_valid || result_ready;
  assign advance    = item_valid && item_ready;
  assign count_ext  = {{COUNT_BITS{1'b0}}, item.byte_count};

  always_comb begin
    case (paddr[2])
      REG_PHASE_TICKS:    prdata = {16'd0, phase_ticks};
      REG_ACK_POLL_LIMIT: prdata = {24'd0, ack_poll_limit};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks    <= PHASE_TICKS_RESET;
      ack_poll_limit <= ACK_POLL_LIMIT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PHASE_TICKS:    phase_ticks    <= pwdata[15:0];
        REG_ACK_POLL_LIMIT: ack_poll_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    tick_count_next     = tick_count;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    poll_count_next     = poll_count;
    device_latch_next   = device_latch;
    register_latch_next = register_latch;
    read_mode_next      = read_mode;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    err_flag_next       = err_flag;
    go                  = 1'b0;
    go_phase            = PH_IDLE;
    taken               = 1'b0;
    rd_ok               = 1'b0;
    done                = 1'b0;
    nack                = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (item.cmd inside {CMD_WRITE, CMD_READ}) begin
          device_latch_next   = item.dev_addr;
          register_latch_next = item.target_reg;
          bytes_left_next     = count_ext[COUNT_BITS-1:0];
          read_mode_next      = (item.cmd == CMD_READ);
          stage_next          = ST_ADDRW;
          err_flag_next       = 1'b0;
          bit_index_next      = 3'd0;
          poll_count_next     = 8'd0;
          go                  = 1'b1;
          go_phase            = PH_ST_SDA_HI;
        end
      end
      PH_ACK_POLL: begin
        if (!item.sda_in) begin
          go       = 1'b1;
          go_phase = PH_ACK_SCLL;
        end else if (poll_count >= ack_poll_limit) begin
          err_flag_next = 1'b1;
          go            = 1'b1;
          go_phase      = PH_SP_SDA_LO;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end
      default: begin
        tick_count_next = tick_count + 16'd1;
        if (tick_count_next >= phase_ticks) begin
          go = 1'b1;
          case (phase)
            PH_ST_SDA_HI: go_phase = PH_ST_SCL_HI;
            PH_ST_SCL_HI: go_phase = PH_ST_SDA_LO;
            PH_ST_SDA_LO: go_phase = PH_ST_SCL_LO;
            PH_ST_SCL_LO: begin
              if (stage == ST_ADDRR) begin
                shift_byte_next = {device_latch, 1'b1};
              end else begin
                stage_next      = ST_ADDRW;
                shift_byte_next = {device_latch, 1'b0};
              end
              bit_index_next = 3'd0;
              go_phase       = PH_TX_SETUP;
            end
            PH_TX_SETUP: go_phase = PH_TX_HIGH;
            PH_TX_HIGH: begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
              bit_index_next  = bit_index + 3'd1;
              go_phase        = (bit_index_next == 3'd0) ? PH_TX_TAIL : PH_TX_SETUP;
            end
            PH_TX_TAIL:  go_phase = PH_ACK_REL;
            PH_ACK_REL:  go_phase = PH_ACK_SCLH;
            PH_ACK_SCLH: begin
              poll_count_next = 8'd0;
              go_phase        = PH_ACK_POLL;
            end
            PH_ACK_SCLL: begin
              case (stage)
                ST_ADDRW: begin
                  stage_next      = ST_REG;
                  shift_byte_next = register_latch;
                  bit_index_next  = 3'd0;
                  go_phase        = PH_TX_SETUP;
                end
                ST_REG, ST_DATA: begin
                  if (stage == ST_REG && read_mode) begin
                    stage_next = ST_ADDRR;
                    go_phase   = PH_ST_SDA_HI;
                  end else begin
                    if (stage == ST_DATA) begin
                      bytes_left_next = bytes_left - COUNT_BITS'(1);
                    end
                    if (bytes_left_next != '0) begin
                      taken           = 1'b1;
                      stage_next      = ST_DATA;
                      shift_byte_next = item.wr_byte;
                      bit_index_next  = 3'd0;
                      go_phase        = PH_TX_SETUP;
                    end else begin
                      go_phase = PH_SP_SDA_LO;
                    end
                  end
                end
                default: begin
                  if (bytes_left != '0) begin
                    bit_index_next = 3'd0;
                    go_phase       = PH_RX_REL;
                  end else begin
                    go_phase = PH_SP_SDA_LO;
                  end
                end
              endcase
            end
            PH_RX_REL: go_phase = PH_RX_HIGH;
            PH_RX_HIGH: begin
              shift_byte_next = {shift_byte[6:0], item.sda_in};
              bit_index_next  = bit_index + 3'd1;
              rd_ok           = (bit_index_next == 3'd0);
              go_phase        = PH_RX_LOW;
            end
            PH_RX_LOW:    go_phase = (bit_index == 3'd0) ? PH_MACK_SDA : PH_RX_HIGH;
            PH_MACK_SDA:  go_phase = PH_MACK_SCLH;
            PH_MACK_SCLH: go_phase = PH_MACK_SCLL;
            PH_MACK_SCLL: begin
              bytes_left_next = bytes_left - COUNT_BITS'(1);
              if (bytes_left_next != '0) begin
                bit_index_next = 3'd0;
                go_phase       = PH_RX_REL;
              end else begin
                go_phase = PH_SP_SDA_LO;
              end
            end
            PH_SP_SDA_LO: go_phase = PH_SP_SCL_HI;
            PH_SP_SCL_HI: go_phase = PH_SP_SDA_HI;
            PH_SP_SDA_HI: begin
              done     = 1'b1;
              nack     = err_flag;
              go_phase = PH_IDLE;
            end
            default: go_phase = PH_IDLE;
          endcase
        end
      end
    endcase

    if (go) begin
      phase_next      = go_phase;
      tick_count_next = 16'd0;
      case (go_phase)
        PH_IDLE: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
        end
        PH_ST_SDA_HI, PH_ACK_REL, PH_RX_REL, PH_SP_SDA_HI: sda_level_next = 1'b1;
        PH_ST_SDA_LO, PH_SP_SDA_LO:                       sda_level_next = 1'b0;
        PH_TX_SETUP: begin
          scl_level_next = 1'b0;
          sda_level_next = shift_byte_next[7];
        end
        PH_MACK_SDA: sda_level_next = (bytes_left_next == COUNT_BITS'(1));
        PH_ST_SCL_HI, PH_TX_HIGH, PH_ACK_SCLH, PH_RX_HIGH, PH_MACK_SCLH,
        PH_SP_SCL_HI: scl_level_next = 1'b1;
        PH_ST_SCL_LO, PH_TX_TAIL, PH_ACK_SCLL, PH_RX_LOW,
        PH_MACK_SCLL: scl_level_next = 1'b0;
        default: ;
      endcase
    end

    result_next.scl         = scl_level_next;
    result_next.sda_release = sda_level_next;
    result_next.busy_res    = (phase_next != PH_IDLE);
    result_next.byte_taken  = taken;
    result_next.rd_byte     = rd_ok ? shift_byte_next : 8'd0;
    result_next.rd_valid    = rd_ok;
    result_next.done_res    = done;
    result_next.nack_error  = nack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= ST_ADDRW;
      tick_count     <= 16'd0;
      bit_index      <= 3'd0;
      shift_byte     <= 8'd0;
      bytes_left     <= '0;
      poll_count     <= 8'd0;
      device_latch   <= 7'd0;
      register_latch <= 8'd0;
      read_mode      <= 1'b0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      err_flag       <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      stage          <= stage_next;
      tick_count     <= tick_count_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      poll_count     <= poll_count_next;
      device_latch   <= device_latch_next;
      register_latch <= register_latch_next;
      read_mode      <= read_mode_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
      err_flag       <= err_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= advance || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  a_idle_bus_high: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> scl_level && sda_level)
    else $error("bus not released while idle");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done_res |-> !result.busy_res)
    else $error("done reported while still busy");

  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.nack_error |-> result.done_res)
    else $error("nack_error without done");

  a_read_write_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rd_valid |-> !result.byte_taken && !result.scl)
    else $error("read byte reported outside the drop of SCL after a read bit");

endmodule

// ===== dv/tb_i2c_register_master.sv =====
// Testbench for the I2C register master: directed and random bus ticks, each result checked against a model sequencer.
module tb_i2c_register_master;
  import i2crm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ALWAYS_ACK = 100000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  i2c_register_master dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [15:0] cfg_hold = PHASE_TICKS_RESET;
  logic [7:0] cfg_polls = ACK_POLL_LIMIT_RESET;

  phase_t seq_phase = PH_IDLE;
  stage_t seq_stage = ST_ADDRW;
  logic [15:0] seq_ticks = '0;
  logic [2:0] seq_bit = '0;
  logic [7:0] seq_shift = '0;
  logic [7:0] seq_left = '0;
  logic [7:0] seq_polls = '0;
  logic [6:0] seq_dev = '0;
  logic [7:0] seq_reg = '0;
  logic seq_read = 1'b0;
  logic seq_scl = 1'b1;
  logic seq_sda = 1'b1;
  logic seq_err = 1'b0;
  logic out_taken, out_valid, out_done, out_err;

  result_t line_levels_due[$];

  int dev_acks = ALWAYS_ACK;
  int dev_hold = -1;
  int dev_polls = 0;

  int send_gap_pct = 25;
  int recv_stall_pct = 86;
  int idle_cycles = 0;

  int n_fail = 0;
  int n_checked = 0;
  int n_ticks = 0;
  int n_transfers = 0;
  int n_nacks = 0;
  int n_wr_bytes = 0;
  int n_rd_bytes = 0;

  logic [7:0] poll_choices [6] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd100, 8'd255};

  function automatic void enter_phase(input phase_t p);
    seq_phase = p;
    seq_ticks = '0;
    case (p)
      PH_IDLE: begin
        seq_scl = 1'b1;
        seq_sda = 1'b1;
      end
      PH_ST_SDA_HI, PH_ACK_REL, PH_RX_REL, PH_SP_SDA_HI: seq_sda = 1'b1;
      PH_ST_SDA_LO, PH_SP_SDA_LO: seq_sda = 1'b0;
      PH_TX_SETUP: begin
        seq_scl = 1'b0;
        seq_sda = seq_shift[7];
      end
      PH_MACK_SDA: seq_sda = (seq_left == 8'd1);
      PH_ST_SCL_HI, PH_TX_HIGH, PH_ACK_SCLH, PH_RX_HIGH, PH_MACK_SCLH, PH_SP_SCL_HI:
        seq_scl = 1'b1;
      PH_ST_SCL_LO, PH_TX_TAIL, PH_ACK_SCLL, PH_RX_LOW, PH_MACK_SCLL: seq_scl = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    seq_shift = b;
    seq_bit = '0;
    enter_phase(PH_TX_SETUP);
  endfunction

  function automatic void next_write(input logic [7:0] wr);
    if (seq_left != 8'd0) begin
      out_taken = 1'b1;
      seq_stage = ST_DATA;
      load_byte(wr);
    end else begin
      enter_phase(PH_SP_SDA_LO);
    end
  endfunction

  function automatic void after_ack(input logic [7:0] wr);
    case (seq_stage)
      ST_ADDRW: begin
        seq_stage = ST_REG;
        load_byte(seq_reg);
      end
      ST_REG: begin
        if (seq_read) begin
          seq_stage = ST_ADDRR;
          enter_phase(PH_ST_SDA_HI);
        end else begin
          next_write(wr);
        end
      end
      ST_DATA: begin
        seq_left = seq_left - 8'd1;
        next_write(wr);
      end
      default: begin
        if (seq_left != 8'd0) begin
          seq_bit = '0;
          enter_phase(PH_RX_REL);
        end else begin
          enter_phase(PH_SP_SDA_LO);
        end
      end
    endcase
  endfunction

  function automatic void step_done(input logic [7:0] wr, input logic sda);
    case (seq_phase)
      PH_ST_SDA_HI: enter_phase(PH_ST_SCL_HI);
      PH_ST_SCL_HI: enter_phase(PH_ST_SDA_LO);
      PH_ST_SDA_LO: enter_phase(PH_ST_SCL_LO);
      PH_ST_SCL_LO: begin
        if (seq_stage == ST_ADDRR) begin
          load_byte({seq_dev, 1'b1});
        end else begin
          seq_stage = ST_ADDRW;
          load_byte({seq_dev, 1'b0});
        end
      end
      PH_TX_SETUP: enter_phase(PH_TX_HIGH);
      PH_TX_HIGH: begin
        seq_shift = {seq_shift[6:0], 1'b0};
        seq_bit = seq_bit + 3'd1;
        enter_phase(seq_bit == 3'd0 ? PH_TX_TAIL : PH_TX_SETUP);
      end
      PH_TX_TAIL: enter_phase(PH_ACK_REL);
      PH_ACK_REL: enter_phase(PH_ACK_SCLH);
      PH_ACK_SCLH: begin
        seq_polls = '0;
        enter_phase(PH_ACK_POLL);
      end
      PH_ACK_SCLL: after_ack(wr);
      PH_RX_REL: enter_phase(PH_RX_HIGH);
      PH_RX_HIGH: begin
        seq_shift = {seq_shift[6:0], sda};
        seq_bit = seq_bit + 3'd1;
        if (seq_bit == 3'd0) out_valid = 1'b1;
        enter_phase(PH_RX_LOW);
      end
      PH_RX_LOW: enter_phase(seq_bit == 3'd0 ? PH_MACK_SDA : PH_RX_HIGH);
      PH_MACK_SDA: enter_phase(PH_MACK_SCLH);
      PH_MACK_SCLH: enter_phase(PH_MACK_SCLL);
      PH_MACK_SCLL: begin
        seq_left = seq_left - 8'd1;
        if (seq_left != 8'd0) begin
          seq_bit = '0;
          enter_phase(PH_RX_REL);
        end else begin
          enter_phase(PH_SP_SDA_LO);
        end
      end
      PH_SP_SDA_LO: enter_phase(PH_SP_SCL_HI);
      PH_SP_SCL_HI: enter_phase(PH_SP_SDA_HI);
      PH_SP_SDA_HI: begin
        out_done = 1'b1;
        out_err = seq_err;
        enter_phase(PH_IDLE);
      end
      default: enter_phase(PH_IDLE);
    endcase
  endfunction

  function automatic result_t step_sequencer(input item_t it);
    result_t r;
    out_taken = 1'b0;
    out_valid = 1'b0;
    out_done = 1'b0;
    out_err = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
        seq_dev = it.dev_addr;
        seq_reg = it.target_reg;
        seq_left = it.byte_count;
        seq_read = (it.cmd == CMD_READ);
        seq_stage = ST_ADDRW;
        seq_err = 1'b0;
        seq_bit = '0;
        seq_polls = '0;
        enter_phase(PH_ST_SDA_HI);
        n_transfers++;
      end
    end else if (seq_phase == PH_ACK_POLL) begin
      if (!it.sda_in) begin
        enter_phase(PH_ACK_SCLL);
      end else if (seq_polls >= cfg_polls) begin
        seq_err = 1'b1;
        enter_phase(PH_SP_SDA_LO);
      end else begin
        seq_polls = seq_polls + 8'd1;
      end
    end else begin
      seq_ticks = seq_ticks + 16'd1;
      if (seq_ticks >= cfg_hold) step_done(it.wr_byte, it.sda_in);
    end
    if (out_taken) n_wr_bytes++;
    if (out_valid) n_rd_bytes++;
    if (out_done && out_err) n_nacks++;
    r.scl = seq_scl;
    r.sda_release = seq_sda;
    r.busy_res = (seq_phase != PH_IDLE);
    r.byte_taken = out_taken;
    r.rd_byte = out_valid ? seq_shift : 8'd0;
    r.rd_valid = out_valid;
    r.done_res = out_done;
    r.nack_error = out_err;
    return r;
  endfunction

  function automatic logic device_sda();
    logic high;
    if (seq_phase != PH_ACK_POLL) begin
      dev_polls = 0;
      return ($urandom_range(0, 1) == 1);
    end
    if (dev_acks == 0) return 1'b1;
    high = (dev_hold < 0) ? ($urandom_range(0, 2) == 0) : (dev_polls < dev_hold);
    if (high) begin
      dev_polls++;
      return 1'b1;
    end
    dev_acks--;
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  function automatic void check_levels(input result_t want, input result_t got);
    n_checked++;
    check_field("scl", 8'(want.scl), 8'(got.scl));
    check_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    check_field("byte_taken", 8'(want.byte_taken), 8'(got.byte_taken));
    check_field("rd_byte", want.rd_byte, got.rd_byte);
    check_field("rd_valid", 8'(want.rd_valid), 8'(got.rd_valid));
    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
    check_field("nack_error", 8'(want.nack_error), 8'(got.nack_error));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (line_levels_due.size() == 0) begin
        if (n_fail < MAX_REPORTS) $error("result transfer with no tick outstanding");
        n_fail++;
      end else begin
        check_levels(line_levels_due.pop_front(), result);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_tick(input item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    n_ticks++;
    line_levels_due.push_back(step_sequencer(it));
  endtask

  task automatic run_tick(input logic [1:0] cmd);
    item_t it;
    it.cmd = cmd;
    it.dev_addr = 7'($urandom_range(0, 127));
    it.target_reg = 8'($urandom_range(0, 255));
    it.byte_count = 8'($urandom_range(0, 255));
    it.wr_byte = 8'($urandom_range(0, 255));
    it.sda_in = device_sda();
    send_tick(it);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (line_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_transfer(input logic [1:0] cmd, input logic [6:0] dev,
                                input logic [7:0] regno, input logic [7:0] cnt);
    item_t it;
    it.cmd = cmd;
    it.dev_addr = dev;
    it.target_reg = regno;
    it.byte_count = cnt;
    it.wr_byte = 8'($urandom_range(0, 255));
    it.sda_in = device_sda();
    send_tick(it);
  endtask

  task automatic finish_transfer(input int busy_cmd_pct);
    logic [1:0] cmd;
    while (seq_phase != PH_IDLE) begin
      cmd = CMD_TICK;
      if ($urandom_range(0, 99) < busy_cmd_pct) cmd = 2'($urandom_range(1, 3));
      run_tick(cmd);
      if ($urandom_range(0, 499) == 0) drain_results();
    end
  endtask

  task automatic do_transfer(input logic [1:0] cmd, input logic [6:0] dev,
                             input logic [7:0] regno, input logic [7:0] cnt,
                             input int acks, input int hold);
    dev_acks = acks;
    dev_hold = hold;
    start_transfer(cmd, dev, regno, cnt);
    finish_transfer(0);
  endtask

  task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_back(input logic idx, input string name, input logic [31:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, 32'd0, rd);
    if (rd !== want) begin
      $error("%s: expected %0h, got %0h", name, want, rd);
      n_fail++;
    end
  endtask

  task automatic set_config(input logic [15:0] hold, input logic [7:0] polls);
    logic [31:0] rd;
    drain_results();
    apb_xfer(1'b1, REG_PHASE_TICKS, {16'd0, hold}, rd);
    cfg_hold = hold;
    apb_xfer(1'b1, REG_ACK_POLL_LIMIT, {24'd0, polls}, rd);
    cfg_polls = polls;
    read_back(REG_PHASE_TICKS, "phase_ticks", {16'd0, hold});
    read_back(REG_ACK_POLL_LIMIT, "ack_poll_limit", {24'd0, polls});
  endtask

  task automatic test_reset_defaults();
    read_back(REG_PHASE_TICKS, "phase_ticks", {16'd0, PHASE_TICKS_RESET});
    read_back(REG_ACK_POLL_LIMIT, "ack_poll_limit", {24'd0, ACK_POLL_LIMIT_RESET});
    do_transfer(CMD_WRITE, 7'h7F, 8'hFF, 8'd1, ALWAYS_ACK, 0);
  endtask

  task automatic test_register_access();
    set_config(16'hFFFF, 8'hFF);
    repeat (3) run_tick(CMD_TICK);
    set_config(16'd1, 8'd0);
    repeat (3) run_tick(CMD_TICK);
  endtask

  task automatic test_write_transfers();
    set_config(16'd1, 8'd3);
    do_transfer(CMD_WRITE, 7'h00, 8'h00, 8'd0, ALWAYS_ACK, 0);
    do_transfer(CMD_WRITE, 7'h55, 8'hAA, 8'd2, ALWAYS_ACK, 1);
    do_transfer(CMD_WRITE, 7'h7F, 8'hFF, 8'd3, ALWAYS_ACK, -1);
  endtask

  task automatic test_read_transfers();
    set_config(16'd1, 8'd3);
    do_transfer(CMD_READ, 7'h00, 8'h00, 8'd0, ALWAYS_ACK, 0);
    do_transfer(CMD_READ, 7'h2A, 8'h55, 8'd1, ALWAYS_ACK, 0);
    dev_acks = ALWAYS_ACK;
    dev_hold = 1;
    start_transfer(CMD_READ, 7'h7F, 8'hFF, 8'd3);
    repeat (12) run_tick(CMD_TICK);
    drain_results();
    finish_transfer(0);
  endtask

  task automatic test_missing_ack();
    set_config(16'd1, 8'd0);
    do_transfer(CMD_WRITE, 7'h7F, 8'hFF, 8'd255, 0, 0);
    set_config(16'd1, 8'd255);
    do_transfer(CMD_READ, 7'h3C, 8'h10, 8'd4, 0, 0);
    set_config(16'd2, 8'd2);
    do_transfer(CMD_WRITE, 7'h11, 8'h22, 8'd1, ALWAYS_ACK, 2);
    do_transfer(CMD_WRITE, 7'h11, 8'h22, 8'd1, ALWAYS_ACK, 3);
    set_config(16'd1, 8'd3);
    do_transfer(CMD_WRITE, 7'h5A, 8'h01, 8'd4, 3, 0);
    do_transfer(CMD_READ, 7'h5A, 8'h02, 8'd2, 2, 1);
  endtask

  task automatic test_ignored_commands();
    run_tick(CMD_UNUSED);
    run_tick(CMD_UNUSED);
    run_tick(CMD_TICK);
    dev_acks = ALWAYS_ACK;
    dev_hold = 0;
    start_transfer(CMD_WRITE, 7'h24, 8'h42, 8'd1);
    finish_transfer(100);
    set_config(16'd0, 8'd3);
    do_transfer(CMD_READ, 7'h6B, 8'hC3, 8'd2, ALWAYS_ACK, 0);
  endtask

  task automatic random_transfer();
    int pick;
    logic [7:0] cnt;
    repeat ($urandom_range(0, 2)) run_tick(($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_UNUSED);
    pick = $urandom_range(0, 9);
    if (pick < 6) cnt = 8'($urandom_range(0, 3));
    else if (pick < 8) cnt = 8'($urandom_range(4, 8));
    else cnt = 8'($urandom_range(0, 255));
    dev_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(cfg_polls) + 1) : -1;
    if (cnt > 8) dev_acks = $urandom_range(0, 1);
    else if ($urandom_range(0, 7) == 0) dev_acks = $urandom_range(0, int'(cnt) + 2);
    else dev_acks = ALWAYS_ACK;
    start_transfer(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ,
                   7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), cnt);
    finish_transfer(5);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int budget);
    int stop_at;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      set_config(16'($urandom_range(0, 3)), poll_choices[3'($urandom_range(0, 5))]);
      stop_at = n_ticks + budget / 2;
      while (n_ticks < stop_at) random_transfer();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_access();
    test_write_transfers();
    test_read_transfers();
    test_missing_ack();
    test_ignored_commands();
    test_random_traffic(25, 86, 150);
    test_random_traffic(86, 25, 150);
    test_random_traffic(0, 0, 150);
    drain_results();
    $display("Sent %0d ticks across %0d bus transactions, %0d ended on a missing ack.",
             n_ticks, n_transfers, n_nacks);
    $display("Saw %0d bytes written and %0d bytes read; compared %0d results.",
             n_wr_bytes, n_rd_bytes, n_checked);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
